@@ hdl/dsbe_pkg.sv @@
// Shared constants, types and helper functions for the deflate symbol bit encoder.
package dsbe_pkg;

  // Default sizes of the code tables and the longest code length.
  localparam int LIT_ENTRIES_DEF   = 288;
  localparam int DIST_ENTRIES_DEF  = 30;
  localparam int MAX_CODE_BITS_DEF = 15;

  // Bit packer word size and code table entry layout.
  localparam int PACK_BITS = 16;
  localparam int CODE_W    = 15;
  localparam int LEN_W     = 4;
  localparam int ENTRY_W   = LEN_W + CODE_W;

  typedef logic [ENTRY_W-1:0] entry_t;

  // Request type codes.
  localparam logic [2:0] REQ_LOAD_LIT  = 3'd0;
  localparam logic [2:0] REQ_LOAD_DIST = 3'd1;
  localparam logic [2:0] REQ_LITERAL   = 3'd2;
  localparam logic [2:0] REQ_MATCH     = 3'd3;
  localparam logic [2:0] REQ_END_BLOCK = 3'd4;
  localparam logic [2:0] REQ_RAW       = 3'd5;
  localparam logic [2:0] REQ_WINDUP    = 3'd6;

  // Literal/length alphabet symbols.
  localparam logic [8:0] END_SYM      = 9'd256;
  localparam logic [8:0] LEN_SYM_BASE = 9'd257;

  // Position of the highest set bit; zero for an input of zero or one.
  function automatic logic [3:0] top_bit(input logic [14:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 1; i < 15; i++) begin
      if (v[i]) begin
        n = 4'(i);
      end
    end
    return n;
  endfunction

  // Mask with the low n bits set, n from 0 to 16.
  function automatic logic [15:0] low_mask(input logic [4:0] n);
    logic [16:0] m;
    m = (17'd1 << n) - 17'd1;
    return m[15:0];
  endfunction

endpackage

@@ hdl/dsbe_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
module dsbe_ram #(
  parameter  int WIDTH = 19,
  parameter  int DEPTH = 288,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/deflate_symbol_bit_encoder_core.sv @@
// Top level of the deflate symbol bit encoder: code table RAMs, symbol mapping and bit packer.
//
//   Channel   Handshake              Payload
//   request   req_valid / req_stall  req_type, table_index, entry_code, entry_len,
//                                    literal_byte, match_len_minus3, match_dist,
//                                    raw_value, raw_len
//   result    res_valid / res_stall  out_word, out_bytes, out_last
//
// A request passes a code table read stage and then the bit packer, which takes one
// code field per cycle unless a stalled result register holds it: literal, end block,
// raw and windup requests carry one field, a match four (length code, length extra,
// distance code, distance extra). Load requests write a table in the cycle they are
// accepted and give no result. Words pass the read stage, packer and result register.
// Reset clears the packer and all valid flags; code tables hold garbage until loaded.
// A stalled result register holds the packer only when it has another word to emit.
module deflate_symbol_bit_encoder_core import dsbe_pkg::*; #(
  parameter int LIT_ENTRIES   = LIT_ENTRIES_DEF,
  parameter int DIST_ENTRIES  = DIST_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  req_type,
  input  logic [8:0]  table_index,
  input  logic [14:0] entry_code,
  input  logic [3:0]  entry_len,
  input  logic [7:0]  literal_byte,
  input  logic [7:0]  match_len_minus3,
  input  logic [15:0] match_dist,
  input  logic [15:0] raw_value,
  input  logic [4:0]  raw_len,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] out_word,
  output logic [1:0]  out_bytes,
  output logic        out_last
);

  localparam int LAW = (LIT_ENTRIES > 1) ? $clog2(LIT_ENTRIES) : 1;
  localparam int DAW = (DIST_ENTRIES > 1) ? $clog2(DIST_ENTRIES) : 1;

  // Handshake and pipeline control.
  logic accept;
  logic pk_take;
  logic pk_free;
  logic pk_step;
  logic pk_done;
  logic out_free;

  // Code table ports.
  logic           lit_wr_en;
  logic           dist_wr_en;
  entry_t         load_entry;
  logic [3:0]     load_len;
  logic [LAW-1:0] lit_rd_addr;
  logic [DAW-1:0] dist_rd_addr;
  entry_t         lit_rd_data;
  entry_t         dist_rd_data;

  // Symbol mapping of the incoming request.
  logic [8:0]  lit_sym;
  logic [3:0]  len_nb;
  logic [4:0]  len_code;
  logic [2:0]  lx_len;
  logic [4:0]  lx_val;
  logic [7:0]  len_shift;
  logic [15:0] len_mask;
  logic [8:0]  len_sym;
  logic [14:0] dist_m1;
  logic [3:0]  dist_nb;
  logic [4:0]  dist_sym;
  logic [3:0]  dx_len;
  logic [12:0] dx_val;
  logic [14:0] dist_shift;
  logic [15:0] dist_mask;
  logic [4:0]  raw_len_sat;
  logic        needs_pack;

  // Table read stage.
  logic        s1_valid;
  logic [2:0]  s1_type;
  logic        s1_lit_ok;
  logic        s1_dist_ok;
  logic [4:0]  s1_lx_val;
  logic [2:0]  s1_lx_len;
  logic [12:0] s1_dx_val;
  logic [3:0]  s1_dx_len;
  logic [15:0] s1_raw_val;
  logic [4:0]  s1_raw_len;

  // Bit packer.
  logic        pk_valid;
  logic        pk_windup;
  logic [1:0]  pk_cnt;
  logic [1:0]  pk_idx;
  logic [15:0] pk_val [4];
  logic [4:0]  pk_len [4];
  logic [15:0] accum;
  logic [4:0]  fill;
  logic [15:0] accum_next;
  logic [4:0]  fill_next;
  logic        emit;
  logic [15:0] emit_word;
  logic [1:0]  emit_bytes;
  logic        emit_last;

  // Request handshake: a new request enters when the read stage is empty or moves on.
  assign pk_take   = s1_valid && pk_free;
  assign req_stall = s1_valid && !pk_take;
  assign accept    = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;

  // Loads write the code tables directly.
  always_comb begin
    load_len   = (entry_len > 4'(MAX_CODE_BITS)) ? 4'(MAX_CODE_BITS) : entry_len;
    load_entry = {load_len, entry_code};
    lit_wr_en  = accept && (req_type == REQ_LOAD_LIT) && (table_index < LIT_ENTRIES);
    dist_wr_en = accept && (req_type == REQ_LOAD_DIST) && (table_index < DIST_ENTRIES);
  end

  // Length code: base range search over the match length minus three.
  always_comb begin
    len_nb    = top_bit({7'd0, match_len_minus3});
    len_code  = match_len_minus3[4:0];
    lx_len    = 3'd0;
    len_shift = match_len_minus3;
    len_mask  = 16'd0;
    if (match_len_minus3 == 8'hff) begin
      len_code = 5'd28;
    end else if (match_len_minus3 >= 8'd8) begin
      lx_len    = 3'(len_nb - 4'd2);
      len_shift = match_len_minus3 >> lx_len;
      len_code  = {3'(len_nb - 4'd1), len_shift[1:0]};
      len_mask  = low_mask({2'd0, lx_len});
    end
    lx_val  = 5'(match_len_minus3 & len_mask[7:0]);
    len_sym = LEN_SYM_BASE + {4'd0, len_code};
  end

  // Distance code: base range search over the distance minus one.
  always_comb begin
    dist_m1    = 15'(match_dist - 16'd1);
    dist_nb    = top_bit(dist_m1);
    dist_sym   = {3'd0, dist_m1[1:0]};
    dx_len     = 4'd0;
    dist_shift = dist_m1;
    dist_mask  = 16'd0;
    if (dist_m1 >= 15'd4) begin
      dx_len     = dist_nb - 4'd1;
      dist_shift = dist_m1 >> dx_len;
      dist_sym   = {dist_nb, dist_shift[0]};
      dist_mask  = low_mask({1'b0, dx_len});
    end
    dx_val = 13'(dist_m1 & dist_mask[14:0]);
  end

  // Literal table address and which requests go on to the packer.
  always_comb begin
    case (req_type)
      REQ_LITERAL:   lit_sym = {1'b0, literal_byte};
      REQ_END_BLOCK: lit_sym = END_SYM;
      REQ_MATCH:     lit_sym = len_sym;
      default:       lit_sym = 9'd0;
    endcase
    lit_rd_addr  = lit_sym[LAW-1:0];
    dist_rd_addr = dist_sym[DAW-1:0];
    raw_len_sat  = (raw_len > 5'(PACK_BITS)) ? 5'(PACK_BITS) : raw_len;
    needs_pack   = (req_type == REQ_LITERAL) || (req_type == REQ_MATCH) ||
                   (req_type == REQ_END_BLOCK) || (req_type == REQ_RAW) ||
                   (req_type == REQ_WINDUP);
  end

  dsbe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LIT_ENTRIES)
  ) u_lit_ram (
    .clk     (clk),
    .wr_en   (lit_wr_en),
    .wr_addr (table_index[LAW-1:0]),
    .wr_data (load_entry),
    .rd_en   (accept),
    .rd_addr (lit_rd_addr),
    .rd_data (lit_rd_data)
  );

  dsbe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DIST_ENTRIES)
  ) u_dist_ram (
    .clk     (clk),
    .wr_en   (dist_wr_en),
    .wr_addr (table_index[DAW-1:0]),
    .wr_data (load_entry),
    .rd_en   (accept),
    .rd_addr (dist_rd_addr),
    .rd_data (dist_rd_data)
  );

  // Read stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= needs_pack;
    end else if (pk_take) begin
      s1_valid <= 1'b0;
    end
  end

  // Read stage payload, captured alongside the table reads.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type    <= req_type;
      s1_lit_ok  <= (lit_sym < LIT_ENTRIES);
      s1_dist_ok <= (dist_sym < DIST_ENTRIES);
      s1_lx_val  <= lx_val;
      s1_lx_len  <= lx_len;
      s1_dx_val  <= dx_val;
      s1_dx_len  <= dx_len;
      s1_raw_val <= raw_value;
      s1_raw_len <= raw_len_sat;
    end
  end

  // One packer step: add the current field, or flush on windup.
  always_comb begin
    logic [15:0] val;
    logic [31:0] shifted;
    logic [5:0]  sum;
    logic [5:0]  s;
    logic [4:0]  f;
    logic        later;
    val        = pk_val[pk_idx] & low_mask(pk_len[pk_idx]);
    shifted    = {16'd0, val} << fill;
    sum        = {1'b0, fill} + {1'b0, pk_len[pk_idx]};
    emit       = 1'b0;
    emit_word  = accum | shifted[15:0];
    emit_bytes = 2'd2;
    accum_next = accum | shifted[15:0];
    fill_next  = sum[4:0];
    if (pk_windup) begin
      emit       = (fill != 5'd0);
      emit_word  = (fill > 5'd8) ? accum : {8'd0, accum[7:0]};
      emit_bytes = (fill > 5'd8) ? 2'd2 : 2'd1;
      accum_next = 16'd0;
      fill_next  = 5'd0;
    end else if (sum > 6'(PACK_BITS)) begin
      emit       = 1'b1;
      accum_next = shifted[31:16];
      fill_next  = 5'(sum - 6'(PACK_BITS));
    end
    // A word is the last of its request when no later field of the request emits.
    f     = fill_next;
    s     = 6'd0;
    later = 1'b0;
    for (int j = 1; j < 4; j++) begin
      if (!pk_windup && (2'(j) > pk_idx) && (2'(j) <= pk_cnt)) begin
        s = {1'b0, f} + {1'b0, pk_len[j]};
        if (s > 6'(PACK_BITS)) begin
          later = 1'b1;
          f     = 5'(s - 6'(PACK_BITS));
        end else begin
          f = s[4:0];
        end
      end
    end
    emit_last = !later;
    pk_step   = pk_valid && (!emit || out_free);
    pk_done   = pk_step && (pk_windup || (pk_idx == pk_cnt));
    pk_free   = !pk_valid || pk_done;
  end

  // Packer control and bit accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      pk_valid <= 1'b0;
      pk_idx   <= 2'd0;
      accum    <= 16'd0;
      fill     <= 5'd0;
    end else begin
      if (pk_step) begin
        accum <= accum_next;
        fill  <= fill_next;
      end
      if (pk_take) begin
        pk_valid <= 1'b1;
        pk_idx   <= 2'd0;
      end else if (pk_done) begin
        pk_valid <= 1'b0;
      end else if (pk_step) begin
        pk_idx <= pk_idx + 2'd1;
      end
    end
  end

  // Field list of the next request, built from the read stage and the table data.
  always_ff @(posedge clk) begin
    if (pk_take) begin
      pk_windup <= (s1_type == REQ_WINDUP);
      pk_cnt    <= (s1_type == REQ_MATCH) ? 2'd3 : 2'd0;
      pk_val[1] <= {11'd0, s1_lx_val};
      pk_len[1] <= {2'd0, s1_lx_len};
      pk_val[2] <= {1'b0, dist_rd_data[CODE_W-1:0]};
      pk_len[2] <= s1_dist_ok ? {1'b0, dist_rd_data[ENTRY_W-1:CODE_W]} : 5'd0;
      pk_val[3] <= {3'd0, s1_dx_val};
      pk_len[3] <= {1'b0, s1_dx_len};
      case (s1_type)
        REQ_RAW: begin
          pk_val[0] <= s1_raw_val;
          pk_len[0] <= s1_raw_len;
        end
        REQ_LITERAL, REQ_END_BLOCK, REQ_MATCH: begin
          pk_val[0] <= {1'b0, lit_rd_data[CODE_W-1:0]};
          pk_len[0] <= s1_lit_ok ? {1'b0, lit_rd_data[ENTRY_W-1:CODE_W]} : 5'd0;
        end
        default: begin
          pk_val[0] <= 16'd0;
          pk_len[0] <= 5'd0;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pk_step && emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pk_step && emit) begin
      out_word  <= emit_word;
      out_bytes <= emit_bytes;
      out_last  <= emit_last;
    end
  end

endmodule
